### sv/nfs_pkg.sv
// Package for the nearest-five selector: widths, beat types, list entry and ordering.
package nfs_pkg;

  localparam int unsigned CoordWidth = 20;
  localparam int unsigned RowWidth   = 24;
  localparam int unsigned DistWidth  = 42;
  localparam int unsigned RankWidth  = 3;
  localparam int unsigned KBestDef   = 5;
  localparam int unsigned SqWidth    = 2 * CoordWidth;
  localparam int unsigned SumWidth   = SqWidth + 2;
  localparam int unsigned AccWidth   = (SumWidth > DistWidth) ? SumWidth : DistWidth;

  localparam logic [DistWidth-1:0] DistMax = '1;

  typedef enum logic {
    KindStart = 1'b0,
    KindCand  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                         kind;
    logic signed [CoordWidth-1:0]  pos_x;
    logic signed [CoordWidth-1:0]  pos_y;
    logic signed [CoordWidth-1:0]  pos_z;
    logic        [RowWidth-1:0]    cand_row;
    logic                          final_candidate;
  } in_beat_t;

  typedef struct packed {
    logic [RankWidth-1:0] rank;
    logic                 found;
    logic [RowWidth-1:0]  neighbor_row;
    logic [DistWidth-1:0] sq_dist;
    logic                 run_end;
  } out_beat_t;

  typedef struct packed {
    logic                 valid;
    logic [DistWidth-1:0] dist_sq;
    logic [RowWidth-1:0]  row;
  } entry_t;

  // insert request leaving the distance pipeline
  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic                 last;
    logic [RowWidth-1:0]  row;
    logic [DistWidth-1:0] dist_sq;
  } ins_t;

  // smaller distance wins; on a tie the larger row wins
  function automatic logic is_nearer(logic [DistWidth-1:0] d1, logic [RowWidth-1:0] r1,
                                     logic [DistWidth-1:0] d2, logic [RowWidth-1:0] r2);
    is_nearer = (d1 < d2) || ((d1 == d2) && (r1 > r2));
  endfunction

endpackage

### sv/nfs_dist.sv
// Three-stage squared-distance pipeline with the query register.
module nfs_dist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              adv_i,
  input  nfs_pkg::in_beat_t beat_i,
  output nfs_pkg::ins_t     ins_o
);
  import nfs_pkg::*;

  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic                last;
    logic [RowWidth-1:0] row;
  } meta_t;

  function automatic logic [CoordWidth-1:0] abs_diff(logic [CoordWidth-1:0] a,
                                                     logic [CoordWidth-1:0] b);
    logic [CoordWidth:0] d;
    logic [CoordWidth:0] n;
    d = {a[CoordWidth-1], a} - {b[CoordWidth-1], b};
    n = -d;
    abs_diff = d[CoordWidth] ? n[CoordWidth-1:0] : d[CoordWidth-1:0];
  endfunction

  logic [CoordWidth-1:0] query_q [3];
  logic [CoordWidth-1:0] pos    [3];
  logic [CoordWidth-1:0] dif_d  [3];
  logic [CoordWidth-1:0] dif_q  [3];
  logic [SqWidth-1:0]    sq_d   [3];
  logic [SqWidth-1:0]    sq_q   [3];
  logic [AccWidth-1:0]   sum;
  logic [DistWidth-1:0]  dist_d;
  logic [DistWidth-1:0]  dist_q;
  meta_t                 a_q, b_q, c_q, a_d;

  assign pos[0] = beat_i.pos_x;
  assign pos[1] = beat_i.pos_y;
  assign pos[2] = beat_i.pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif_d[i] = abs_diff(pos[i], query_q[i]);
      sq_d[i]  = {{CoordWidth{1'b0}}, dif_q[i]} * {{CoordWidth{1'b0}}, dif_q[i]};
    end
  end

  assign sum    = AccWidth'(sq_q[0]) + AccWidth'(sq_q[1]) + AccWidth'(sq_q[2]);
  assign dist_d = (sum > AccWidth'(DistMax)) ? DistMax : sum[DistWidth-1:0];

  assign a_d = '{valid: fire_i, kind: beat_i.kind, last: beat_i.final_candidate,
                 row: beat_i.cand_row};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) query_q[i] <= '0;
    end else if (fire_i && beat_i.kind == KindStart) begin
      for (int i = 0; i < 3; i++) query_q[i] <= pos[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
    end else if (adv_i) begin
      a_q <= a_d;
      b_q <= a_q;
      c_q <= b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dif_q  <= dif_d;
      sq_q   <= sq_d;
      dist_q <= dist_d;
    end
  end

  assign ins_o = '{valid: c_q.valid, kind: c_q.kind, last: c_q.last, row: c_q.row,
                   dist_sq: dist_q};

endmodule

### sv/nfs_cell.sv
// One rank of the sorted neighbor list: compare against the candidate, shift or insert.
module nfs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_i,
  input  logic            clr_i,
  input  nfs_pkg::entry_t cand_i,
  input  nfs_pkg::entry_t prev_i,
  input  logic            prev_near_i,
  output logic            near_o,
  output nfs_pkg::entry_t ent_o,
  output nfs_pkg::entry_t ent_d_o
);
  import nfs_pkg::*;

  entry_t ent_q, ent_d;

  assign near_o = !ent_q.valid ||
                  is_nearer(cand_i.dist_sq, cand_i.row, ent_q.dist_sq, ent_q.row);

  always_comb begin
    ent_d = ent_q;
    if (clr_i) begin
      ent_d.valid = 1'b0;
    end else if (upd_i && near_o) begin
      ent_d = prev_near_i ? prev_i : cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '{valid: 1'b0, dist_sq: DistMax, row: '0};
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o   = ent_q;
  assign ent_d_o = ent_d;

endmodule

### sv/nfs_drain.sv
// Result shifter: holds a snapshot of the list and sends one rank per beat.
module nfs_drain #(
  parameter int unsigned K_BEST = nfs_pkg::KBestDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  nfs_pkg::entry_t    snap_i [K_BEST],
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nfs_pkg::out_beat_t out_data_o
);
  import nfs_pkg::*;

  localparam int unsigned IdxWidth = (K_BEST > 1) ? $clog2(K_BEST) : 1;

  logic                busy_q, busy_d;
  logic [IdxWidth-1:0] idx_q, idx_d;
  entry_t              shift_q [K_BEST];
  entry_t              shift_d [K_BEST];
  logic                pop;
  logic                at_last;

  assign pop     = busy_q && out_ready_i;
  assign at_last = (idx_q == IdxWidth'(K_BEST - 1));

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    if (load_i) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      shift_d = snap_i;
    end else if (pop) begin
      idx_d = idx_q + 1'b1;
      for (int i = 0; i < K_BEST - 1; i++) shift_d[i] = shift_q[i+1];
      if (at_last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign busy_o      = busy_q;
  assign out_valid_o = busy_q;

  always_comb begin
    out_data_o.rank         = RankWidth'(idx_q);
    out_data_o.found        = shift_q[0].valid;
    out_data_o.neighbor_row = shift_q[0].valid ? shift_q[0].row : '0;
    out_data_o.sq_dist      = shift_q[0].valid ? shift_q[0].dist_sq : '0;
    out_data_o.run_end      = at_last;
  end

endmodule

### sv/nearest_five_selector_unit.sv
// Top level of the nearest-five selector: distance pipeline, cell chain, result shifter.
//
//   channel | signals                           | payload
//   --------+-----------------------------------+---------------------
//   in      | in_valid_i / in_ready_o           | nfs_pkg::in_beat_t
//   out     | out_valid_o / out_ready_i         | nfs_pkg::out_beat_t
// One in beat per cycle while in_ready_o is high; a candidate passes the difference,
// square and distance registers before the cell chain. A final candidate sends K_BEST
// out beats, one per cycle while out_ready_i is high, from a snapshot register bank.
// A final candidate at the chain input waits while the previous run still drains; the whole
// in side stalls with it.
// Reset clears the query and the list at once; there is no clearing pass.
module nearest_five_selector_unit #(
  parameter int unsigned K_BEST = nfs_pkg::KBestDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nfs_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nfs_pkg::out_beat_t out_data_o
);
  import nfs_pkg::*;

  ins_t   ins;
  entry_t cand;
  entry_t ent_q  [K_BEST];
  entry_t ent_d  [K_BEST];
  entry_t prev   [K_BEST];
  logic   near   [K_BEST];
  logic   pnear  [K_BEST];
  logic   busy;
  logic   adv;
  logic   fire;
  logic   is_final;
  logic   upd;
  logic   clr;
  logic   load;

  assign is_final   = ins.valid && ins.kind == KindCand && ins.last;
  assign adv        = !(is_final && busy);
  assign in_ready_o = adv;
  assign fire       = in_valid_i && adv;
  assign upd        = ins.valid && adv && ins.kind == KindCand;
  assign clr        = ins.valid && adv && ins.kind == KindStart;
  assign load       = is_final && adv;
  assign cand       = '{valid: 1'b1, dist_sq: ins.dist_sq, row: ins.row};

  nfs_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .adv_i  (adv),
    .beat_i (in_data_i),
    .ins_o  (ins)
  );

  for (genvar k = 0; k < K_BEST; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev[k]  = '{valid: 1'b0, dist_sq: DistMax, row: '0};
      assign pnear[k] = 1'b0;
    end else begin : g_link
      assign prev[k]  = ent_q[k-1];
      assign pnear[k] = near[k-1];
    end

    nfs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .upd_i       (upd),
      .clr_i       (clr),
      .cand_i      (cand),
      .prev_i      (prev[k]),
      .prev_near_i (pnear[k]),
      .near_o      (near[k]),
      .ent_o       (ent_q[k]),
      .ent_d_o     (ent_d[k])
    );
  end

  nfs_drain #(
    .K_BEST (K_BEST)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .snap_i      (ent_d),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !busy)
    else $error("snapshot loaded while a run is draining");

  a_found_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.found && !out_data_o.run_end)
      |=> (out_valid_o && !out_data_o.found))
    else $error("found rank after an empty rank");

  for (genvar k = 0; k + 1 < K_BEST; k++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ent_q[k+1].valid |-> (ent_q[k].valid &&
        !is_nearer(ent_q[k+1].dist_sq, ent_q[k+1].row, ent_q[k].dist_sq, ent_q[k].row)))
      else $error("neighbor list out of order");
  end

endmodule

### sim/tb_nearest_five_selector_unit.sv
// Self-checking testbench for the nearest-five selector with a 3-D distance and list tracker.
`timescale 1ns / 100ps

module tb_nearest_five_selector_unit;
  import nfs_pkg::*;

  localparam int NBest      = KBestDef;
  localparam int StallLimit = 3000;
  localparam int LongHold   = 300;
  localparam int TailCycles = 20;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  in_beat_t  pending_beats[$];
  out_beat_t expected_ranks[$];

  logic [CoordWidth-1:0] query_pos [3];
  logic [DistWidth-1:0]  near_dist [NBest];
  logic [RowWidth-1:0]   near_row  [NBest];
  int                    near_count;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int phase_id    = 0;
  int err_count   = 0;
  int in_count    = 0;
  int idle_cycles = 0;
  bit in_taken    = 1'b0;
  bit rx_hold     = 1'b0;

  nearest_five_selector_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [63:0] axis_sq(logic [CoordWidth-1:0] a, logic [CoordWidth-1:0] b);
    logic signed [CoordWidth:0] d;
    logic [63:0]                m;
    d = $signed({a[CoordWidth-1], a}) - $signed({b[CoordWidth-1], b});
    m = (d < 0) ? 64'(-d) : 64'(d);
    return m * m;
  endfunction

  task automatic clear_list();
    int i;
    for (i = 0; i < NBest; i++) begin
      near_dist[i] = DistMax;
      near_row[i]  = '0;
    end
    near_count = 0;
  endtask

  task automatic queue_beat(in_beat_t b);
    pending_beats = {pending_beats, b};
  endtask

  // keeps the sorted neighbor list and queues the per-rank beats of a final candidate
  task automatic track_beat(in_beat_t b);
    logic [63:0]          s;
    logic [DistWidth-1:0] d;
    out_beat_t            r;
    int                   pos;
    int                   cnt;
    int                   k;
    if (b.kind == KindStart) begin
      query_pos[0] = b.pos_x;
      query_pos[1] = b.pos_y;
      query_pos[2] = b.pos_z;
      clear_list();
    end else begin
      s = axis_sq(query_pos[0], b.pos_x) + axis_sq(query_pos[1], b.pos_y)
        + axis_sq(query_pos[2], b.pos_z);
      if (s > 64'(DistMax)) s = 64'(DistMax);
      d = s[DistWidth-1:0];
      pos = 0;
      while (pos < near_count && pos < NBest &&
             !(d < near_dist[pos] || (d == near_dist[pos] && b.cand_row > near_row[pos])))
        pos++;
      if (pos < NBest) begin
        cnt = (near_count + 1 > NBest) ? NBest : near_count + 1;
        for (k = cnt - 1; k > pos; k--) begin
          near_dist[k] = near_dist[k-1];
          near_row[k]  = near_row[k-1];
        end
        near_dist[pos] = d;
        near_row[pos]  = b.cand_row;
        near_count     = cnt;
      end
      if (b.final_candidate) begin
        for (k = 0; k < NBest; k++) begin
          r.rank         = RankWidth'(k);
          r.found        = (k < near_count);
          r.neighbor_row = r.found ? near_row[k] : '0;
          r.sq_dist      = r.found ? near_dist[k] : '0;
          r.run_end      = (k == NBest - 1);
          expected_ranks = {expected_ranks, r};
        end
      end
    end
  endtask

  function automatic in_beat_t make_beat(kind_e k, int x, int y, int z,
                                         int unsigned row, int fin);
    in_beat_t b;
    b.kind            = k;
    b.pos_x           = CoordWidth'(x);
    b.pos_y           = CoordWidth'(y);
    b.pos_z           = CoordWidth'(z);
    b.cand_row        = RowWidth'(row);
    b.final_candidate = (fin != 0);
    return b;
  endfunction

  // start beat followed by a run of candidates, the last one final
  task automatic push_query_run(int n_cand);
    int mode;
    int cx, cy, cz;
    int spread;
    int i;
    mode   = $urandom_range(0, 2);
    spread = (mode == 0) ? 3 : 1000;
    cx     = $urandom;
    cy     = $urandom;
    cz     = $urandom;
    queue_beat(make_beat(KindStart, cx, cy, cz, $urandom, $urandom_range(0, 1)));
    for (i = 0; i < n_cand; i++) begin
      if (mode == 2)
        queue_beat(make_beat(KindCand, $urandom, $urandom, $urandom, $urandom,
                             i == n_cand - 1));
      else
        queue_beat(make_beat(KindCand,
          cx + int'($urandom_range(0, 2 * spread)) - spread,
          cy + int'($urandom_range(0, 2 * spread)) - spread,
          cz + int'($urandom_range(0, 2 * spread)) - spread,
          (mode == 0) ? $urandom_range(0, 7) : $urandom, i == n_cand - 1));
    end
  endtask

  task automatic fill_phase(int n_items);
    int added;
    int n;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < 15) begin
        queue_beat(make_beat($urandom_range(0, 1) ? KindCand : KindStart,
                             $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(0, 3) == 0));
        added++;
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 9);
        push_query_run(n);
        added += n + 1;
      end
    end
  endtask

  task automatic drain_all();
    while (pending_beats.size() != 0 || in_valid || expected_ranks.size() != 0)
      @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_ni && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : port_monitor
    out_beat_t want;
    in_taken = rst_ni && in_valid && in_ready;
    if (in_taken) begin
      track_beat(in_data);
      in_count++;
    end
    if (rst_ni && out_valid && out_ready) begin
      if (expected_ranks.size() == 0) begin
        report_error($sformatf("out beat with nothing expected, rank %0d", out_data.rank));
      end else begin
        want = expected_ranks.pop_front();
        if (out_data.rank != want.rank)
          report_error($sformatf("rank %0d, expected %0d", out_data.rank, want.rank));
        if (out_data.found != want.found)
          report_error($sformatf("rank %0d found %0b, expected %0b",
                                 want.rank, out_data.found, want.found));
        if (out_data.neighbor_row != want.neighbor_row)
          report_error($sformatf("rank %0d neighbor_row %0d, expected %0d",
                                 want.rank, out_data.neighbor_row, want.neighbor_row));
        if (out_data.sq_dist != want.sq_dist)
          report_error($sformatf("rank %0d sq_dist %0d, expected %0d",
                                 want.rank, out_data.sq_dist, want.sq_dist));
        if (out_data.run_end != want.run_end)
          report_error($sformatf("rank %0d run_end %0b, expected %0b",
                                 want.rank, out_data.run_end, want.run_end));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("timeout: no beat moved for %0d cycles", StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // long receiver hold-off while the sender keeps going, to back up the block
  initial begin : rx_holdoff
    int mark;
    wait (phase_id == 2);
    mark = in_count + 30;
    while (in_count < mark) @(posedge clk);
    rx_hold = 1'b1;
    repeat (LongHold) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    query_pos[0] = '0;
    query_pos[1] = '0;
    query_pos[2] = '0;
    clear_list();
    tx_idle_pct = 13;
    rx_idle_pct = 66;

    // candidates before any start, measured from the zero query, then reported twice
    queue_beat(make_beat(KindCand, -524288, -524288, -524288, 0, 0));
    queue_beat(make_beat(KindCand, 524287, 524287, 524287, 24'hFFFFFF, 1));
    queue_beat(make_beat(KindCand, 0, 0, 0, 5, 1));
    // start with final set gives nothing; largest distance next
    queue_beat(make_beat(KindStart, 524287, 524287, 524287, 123, 1));
    queue_beat(make_beat(KindCand, -524288, -524288, -524288, 7, 1));
    // ties, overflowing list, dropped candidates
    queue_beat(make_beat(KindStart, 0, 0, 0, 0, 0));
    queue_beat(make_beat(KindCand, 1, 0, 0, 10, 0));
    queue_beat(make_beat(KindCand, 0, 1, 0, 20, 0));
    queue_beat(make_beat(KindCand, 0, 0, -1, 20, 0));
    queue_beat(make_beat(KindCand, 0, 0, 0, 1, 0));
    queue_beat(make_beat(KindCand, 2, 0, 0, 3, 0));
    queue_beat(make_beat(KindCand, 0, -2, 0, 9, 0));
    queue_beat(make_beat(KindCand, 0, 0, 2, 3, 0));
    queue_beat(make_beat(KindCand, 3, 3, 3, 24'hFFFFFF, 0));
    queue_beat(make_beat(KindCand, 0, 0, 0, 0, 1));
    // all-ones start, candidate on top of the query
    queue_beat(make_beat(KindStart, -1, -1, -1, 24'hFFFFFF, 1));
    queue_beat(make_beat(KindCand, -1, -1, -1, 24'hFFFFFF, 1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    fill_phase(100);
    drain_all();

    phase_id    = 1;
    tx_idle_pct = 66;
    rx_idle_pct = 13;
    fill_phase(100);
    drain_all();

    phase_id    = 2;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fill_phase(100);
    drain_all();

    repeat (TailCycles) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
